// File: rtl/core/luc_pkg.sv
package luc_pkg;

  localparam int unsigned ROUNDS = 16;

  // data tag carried on s_tuser
  localparam logic CMD_ENC = 1'b0;
  localparam logic CMD_DEC = 1'b1;

  // key-byte schedule: start value and per-round advance
  localparam logic [3:0] CTL_ENC_START = 4'd0;
  localparam logic [3:0] CTL_DEC_START = 4'd9;
  localparam logic [3:0] CTL_ENC_STEP  = 4'd7;
  localparam logic [3:0] CTL_DEC_STEP  = 4'd9;

  // configuration register indexes
  localparam logic CFG_KEY_LOW  = 1'b0;
  localparam logic CFG_KEY_HIGH = 1'b1;

  localparam logic [2:0] DIFF_OFS [8] = '{3'd7, 3'd6, 3'd2, 3'd1, 3'd5, 3'd0, 3'd3, 3'd4};
  localparam logic [2:0] BIT_PERM [8] = '{3'd2, 3'd5, 3'd4, 3'd0, 3'd3, 3'd1, 3'd7, 3'd6};

  localparam logic [3:0] SBOX_A [16] = '{
    4'd12, 4'd15, 4'd7, 4'd10, 4'd14, 4'd13, 4'd11, 4'd0,
    4'd2,  4'd6,  4'd3, 4'd1,  4'd9,  4'd4,  4'd5,  4'd8
  };
  localparam logic [3:0] SBOX_B_PLAIN [16] = '{
    4'd7,  4'd2,  4'd14, 4'd9,  4'd3, 4'd11, 4'd0, 4'd4,
    4'd12, 4'd13, 4'd1,  4'd10, 4'd6, 4'd15, 4'd8, 4'd5
  };
  localparam logic [3:0] SBOX_B_MIXED [16] = '{
    4'd7, 4'd2, 4'd14, 4'd9, 4'd10, 4'd1,  4'd13, 4'd12,
    4'd4, 4'd0, 4'd11, 4'd3, 4'd6,  4'd15, 4'd8,  4'd5
  };

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  typedef struct packed {
    logic load;     // take a new request into the round registers
    logic step;     // run one round
    logic capture;  // final round: write result register
  } dp_cmd_t;

endpackage

// File: rtl/core/luc_ctrl.sv
module luc_ctrl import luc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  output logic    s_tready,
  output logic    m_tvalid,
  input  logic    m_tready,
  output dp_cmd_t cmd
);

  state_t     state, state_next;
  logic [3:0] rnd, rnd_next;
  logic       out_valid, out_valid_next;
  logic       last, out_free, step, capture, load;

  assign last     = (rnd == 4'(ROUNDS - 1));
  assign out_free = !out_valid || m_tready;
  assign step     = (state == ST_RUN) && (!last || out_free);
  assign capture  = (state == ST_RUN) && last && out_free;
  // a new request may enter in the cycle the previous one finishes
  assign s_tready = (state == ST_IDLE) || capture;
  assign load     = s_tvalid && s_tready;

  assign cmd.load    = load;
  assign cmd.step    = step;
  assign cmd.capture = capture;
  assign m_tvalid    = out_valid;

  always_comb begin
    state_next     = state;
    rnd_next       = rnd;
    out_valid_next = out_valid;
    if (capture) begin
      out_valid_next = 1'b1;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end
    case (state)
      ST_IDLE: begin
        if (load) begin
          state_next = ST_RUN;
          rnd_next   = '0;
        end
      end
      ST_RUN: begin
        if (step) begin
          rnd_next = rnd + 4'd1;
        end
        if (capture) begin
          state_next = load ? ST_RUN : ST_IDLE;
          rnd_next   = '0;
        end
      end
      default: begin
        state_next = ST_IDLE;
        rnd_next   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rnd       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rnd       <= rnd_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// File: rtl/core/luc_dp.sv
module luc_dp import luc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  dp_cmd_t       cmd,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [63:0]   cfg_data,
  input  logic          in_cmd,
  input  logic [63:0]   in_low,
  input  logic [63:0]   in_high,
  output logic [63:0]   res_low,
  output logic [63:0]   res_high
);

  logic [63:0]  key_lo, key_hi;
  logic [127:0] key_all;
  logic [63:0]  blk_a, blk_b;   // a: half being updated, b: half feeding the round
  logic [3:0]   ctl;
  logic         dec;
  logic         mixed;
  logic [63:0]  fout;
  logic [63:0]  b_next;

  assign key_all = {key_hi, key_lo};

  always_comb begin
    logic [7:0] src;
    logic [7:0] sel_byte;
    logic [7:0] kj;
    logic [3:0] a_in, b_in, b_val;
    logic [7:0] v;
    logic [2:0] dst;
    logic [2:0] p;
    fout     = '0;
    sel_byte = key_all[{ctl, 3'b000} +: 8];
    for (int j = 0; j < 8; j++) begin
      src = blk_b[8*j +: 8];
      // key bit picks which nibble goes to which box
      a_in  = sel_byte[j] ? src[3:0] : src[7:4];
      b_in  = sel_byte[j] ? src[7:4] : src[3:0];
      b_val = mixed ? SBOX_B_MIXED[b_in] : SBOX_B_PLAIN[b_in];
      v     = {b_val, SBOX_A[a_in]};
      kj    = key_all[{ctl + 4'(j), 3'b000} +: 8];
      for (int k = 0; k < 8; k++) begin
        dst = DIFF_OFS[k] + 3'(j);
        p   = BIT_PERM[k];
        fout[{dst, 3'(k)}] = kj[p] ^ v[p];
      end
    end
    b_next = blk_a ^ fout;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_lo <= '0;
      key_hi <= '0;
      mixed  <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_KEY_LOW) begin
          key_lo <= cfg_data;
        end else if (cfg_index == CFG_KEY_HIGH) begin
          key_hi <= cfg_data;
        end
      end
      if (cmd.load && in_cmd == CMD_DEC) begin
        mixed <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      blk_a <= in_low;
      blk_b <= in_high;
      dec   <= (in_cmd == CMD_DEC);
      ctl   <= (in_cmd == CMD_DEC) ? CTL_DEC_START : CTL_ENC_START;
    end else if (cmd.step) begin
      blk_a <= blk_b;
      blk_b <= b_next;
      ctl   <= ctl + (dec ? CTL_DEC_STEP : CTL_ENC_STEP);
    end
    // halves swap once more after the last round
    if (cmd.capture) begin
      res_low  <= b_next;
      res_high <= blk_b;
    end
  end

endmodule

// File: rtl/core/lucifer_block_cipher_core.sv
// Lucifer 128-bit block cipher core, 16 rounds, 128-bit key.
//
// Key: write key bytes 0..7 to cfg index 0 and bytes 8..15 to index 1
// over the cfg channel (cfg_ready is always high). Write only while idle.
// Input request: s_tdata = {block_high, block_low}, s_tuser = 0 encipher,
// 1 decipher. Result: m_tdata = {out_high, out_low}.
// Each request runs 16 rounds through one round unit, one round a cycle
// while not held in its last round by a stalled receiver. A new request
// is taken in the cycle the previous one writes its result.
// The result sits in an output register; if the receiver stalls, the core
// still takes the next request and runs it, then holds in its last round
// until the pending result is taken.
// Any decipher switches S-box B to its mixed form for all later requests,
// encipher included, until reset. Reset clears the key, that flag and all
// handshake state.
module lucifer_block_cipher_core import luc_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic           cfg_index,
  input  logic [63:0]    cfg_data,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [127:0]   s_tdata,   // block_low[63:0], block_high[127:64]
  input  logic           s_tuser,   // cmd
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [127:0]   m_tdata    // out_low[63:0], out_high[127:64]
);

  dp_cmd_t     cmd;
  logic [63:0] res_low, res_high;

  assign cfg_ready = 1'b1;

  luc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  luc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_cmd    (s_tuser),
    .in_low    (s_tdata[63:0]),
    .in_high   (s_tdata[127:64]),
    .res_low   (res_low),
    .res_high  (res_high)
  );

  assign m_tdata = {res_high, res_low};

endmodule

// File: verif/lucifer_block_cipher_checker.sv
module lucifer_block_cipher_checker import luc_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_valid,
  input  logic           cfg_ready,
  input  logic           cfg_index,
  input  logic [63:0]    cfg_data,
  input  logic           s_tvalid,
  input  logic           s_tready,
  input  logic [127:0]   s_tdata,   // block_low[63:0], block_high[127:64]
  input  logic           s_tuser,   // cmd
  input  logic           m_tvalid,
  input  logic           m_tready,
  input  logic [127:0]   m_tdata,   // out_low[63:0], out_high[127:64]
  output int unsigned    fail_count,
  output int unsigned    blocks_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] SPREAD [8] = '{3'd7, 3'd6, 3'd2, 3'd1, 3'd5, 3'd0, 3'd3, 3'd4};
  localparam logic [2:0] PICK   [8] = '{3'd2, 3'd5, 3'd4, 3'd0, 3'd3, 3'd1, 3'd7, 3'd6};
  localparam logic [3:0] SUB_A [16] = '{
    4'd12, 4'd15, 4'd7, 4'd10, 4'd14, 4'd13, 4'd11, 4'd0,
    4'd2,  4'd6,  4'd3, 4'd1,  4'd9,  4'd4,  4'd5,  4'd8
  };
  localparam logic [3:0] SUB_B [16] = '{
    4'd7,  4'd2,  4'd14, 4'd9,  4'd3, 4'd11, 4'd0, 4'd4,
    4'd12, 4'd13, 4'd1,  4'd10, 4'd6, 4'd15, 4'd8, 4'd5
  };
  localparam logic [3:0] SUB_B_MIX [16] = '{
    4'd7, 4'd2, 4'd14, 4'd9, 4'd10, 4'd1,  4'd13, 4'd12,
    4'd4, 4'd0, 4'd11, 4'd3, 4'd6,  4'd15, 4'd8,  4'd5
  };

  logic [127:0] key;         // {key_high, key_low}; bit {kbyte, bit}
  logic         sub_b_mixed; // sticky once any decipher is taken
  logic [127:0] cipher_out_queue [$];
  logic [127:0] want;
  int unsigned  result_num;

  function automatic logic [3:0] sub_b(input logic [3:0] n, input logic mixed);
    return mixed ? SUB_B_MIX[n] : SUB_B[n];
  endfunction

  // returns {out_high, out_low}
  function automatic logic [127:0] lucifer_rounds(input logic decipher,
                                                 input logic [127:0] blk,
                                                 input logic [127:0] k,
                                                 input logic mixed);
    logic [63:0] hv [2];
    logic [3:0]  ctl;
    logic [3:0]  sel;
    logic [7:0]  src;
    logic [7:0]  v;
    logic [2:0]  dpos;
    logic [2:0]  p;
    int          h0;
    hv[0] = blk[63:0];
    hv[1] = blk[127:64];
    ctl = decipher ? 4'd8 : 4'd0;
    h0 = 0;
    for (int r = 0; r < 16; r++) begin
      if (decipher) ctl = ctl + 4'd1;
      sel = ctl;
      for (int b = 0; b < 8; b++) begin
        src = hv[1 - h0][8*b +: 8];
        // key bit picks which nibble feeds which box
        if (k[{sel, b[2:0]}]) v = {sub_b(src[7:4], mixed), SUB_A[src[3:0]]};
        else v = {sub_b(src[3:0], mixed), SUB_A[src[7:4]]};
        for (int t = 0; t < 8; t++) begin
          dpos = SPREAD[t] + b[2:0];
          p = PICK[t];
          hv[h0][{dpos, t[2:0]}] = hv[h0][{dpos, t[2:0]}] ^ k[{ctl, p}] ^ v[p];
        end
        if (b < 7 || decipher) ctl = ctl + 4'd1;
      end
      h0 = 1 - h0;
    end
    return {hv[0], hv[1]};
  endfunction

  task automatic report_field(input string field, input logic [63:0] exp_v,
                              input logic [63:0] got_v);
    if (fail_count < 10)
      $display("result %0d %s mismatch: expected %016h got %016h",
               result_num, field, exp_v, got_v);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    blocks_owed = 0;
    result_num = 0;
    key = '0;
    sub_b_mixed = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      key = '0;
      sub_b_mixed = 1'b0;
      cipher_out_queue.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_KEY_LOW) key[63:0] = cfg_data;
        else key[127:64] = cfg_data;
      end
      // results first: a result can never belong to a request taken this edge
      if (m_tvalid && m_tready) begin
        if (cipher_out_queue.size() == 0) begin
          if (fail_count < 10)
            $display("result %0d unexpected: got %032h", result_num, m_tdata);
          fail_count++;
        end else begin
          want = cipher_out_queue.pop_front();
          if (m_tdata[63:0] !== want[63:0])
            report_field("out_low", want[63:0], m_tdata[63:0]);
          if (m_tdata[127:64] !== want[127:64])
            report_field("out_high", want[127:64], m_tdata[127:64]);
        end
        result_num++;
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser == CMD_DEC) sub_b_mixed = 1'b1;
        cipher_out_queue.push_back(lucifer_rounds(s_tuser == CMD_DEC, s_tdata, key,
                                                  sub_b_mixed));
      end
    end
    blocks_owed = cipher_out_queue.size();
  end

endmodule

// File: verif/lucifer_block_cipher_core_test.sv
module lucifer_block_cipher_core_test;
  import luc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam logic [63:0] ALT5 = 64'h5555_5555_5555_5555;
  localparam logic [63:0] ALTA = 64'hAAAA_AAAA_AAAA_AAAA;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           cfg_valid = 1'b0;
  logic           cfg_ready;
  logic           cfg_index = CFG_KEY_LOW;
  logic [63:0]    cfg_data = '0;
  logic           s_tvalid = 1'b0;
  logic           s_tready;
  logic [127:0]   s_tdata = '0;   // block_low[63:0], block_high[127:64]
  logic           s_tuser = CMD_ENC; // cmd
  logic           m_tvalid;
  logic           m_tready = 1'b0;
  logic [127:0]   m_tdata;        // out_low[63:0], out_high[127:64]

  int unsigned    fail_count;
  int unsigned    blocks_owed;
  int unsigned    cycle_count = 0;
  int unsigned    rx_tick = 0;
  int unsigned    rx_mode = 0;

  lucifer_block_cipher_core dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  lucifer_block_cipher_checker checker_i (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .fail_count(fail_count), .blocks_owed(blocks_owed)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("lucifer_block_cipher_core_test: errors");
      $finish;
    end
  end

  // receiver: stall pattern is redrawn at random from four modes
  always @(negedge clk) begin
    if (rx_tick % 256 == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      2: m_tready <= ((rx_tick % 41) < 25);
      default: m_tready <= ((rx_tick % 97) >= 60);
    endcase
    rx_tick++;
  end

  function automatic logic [63:0] pick_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 64'd1 << $urandom_range(0, 63);
      3: return ~(64'd1 << $urandom_range(0, 63));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic key_write(input logic idx, input logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic block_send(input logic cmd, input logic [127:0] blk);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= blk;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic sender_gap(input int n);
    if (n > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // sender holds off until every result is back; core is idle after that
  task automatic drain();
    sender_gap(1);
    while (blocks_owed != 0) @(negedge clk);
  endtask

  task automatic rekey(input int mode);
    drain();
    case (mode)
      0: begin key_write(CFG_KEY_LOW, '0); key_write(CFG_KEY_HIGH, '0); end
      1: begin key_write(CFG_KEY_LOW, '1); key_write(CFG_KEY_HIGH, '1); end
      2: begin key_write(CFG_KEY_LOW, '0); key_write(CFG_KEY_HIGH, '1); end
      default: begin
        case ($urandom_range(0, 3))
          0: key_write(CFG_KEY_LOW, pick_word());
          1: key_write(CFG_KEY_HIGH, pick_word());
          default: begin
            key_write(CFG_KEY_LOW, pick_word());
            key_write(CFG_KEY_HIGH, pick_word());
          end
        endcase
      end
    endcase
  endtask

  task automatic random_blocks(input int n, input bit allow_dec);
    int left;
    int burst;
    logic cmd;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(1, 12);
      for (int i = 0; i < burst && left > 0; i++) begin
        cmd = (allow_dec && $urandom_range(0, 1) == 1) ? CMD_DEC : CMD_ENC;
        block_send(cmd, {pick_word(), pick_word()});
        left--;
      end
      case ($urandom_range(0, 7))
        0, 1, 2: sender_gap(0);
        3: sender_gap($urandom_range(20, 45));
        default: sender_gap($urandom_range(1, 8));
      endcase
    end
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // key still zero from reset, plain S-box
    block_send(CMD_ENC, '0);
    block_send(CMD_ENC, '1);

    rekey(1);
    block_send(CMD_ENC, '0);
    block_send(CMD_ENC, '1);
    block_send(CMD_ENC, {ALT5, ALT5});
    block_send(CMD_ENC, {ALTA, ALTA});

    rekey(2);
    block_send(CMD_ENC, {ALTA, ALT5});
    block_send(CMD_ENC, {64'd1, 64'h8000_0000_0000_0000});

    // plain S-box can only be reached before the first decipher
    rekey(3);
    random_blocks(60, 1'b0);
    rekey(3);
    random_blocks(60, 1'b0);

    // first decipher flips S-box B for good; later encipher keeps it
    rekey(1);
    block_send(CMD_DEC, '0);
    block_send(CMD_DEC, '1);
    block_send(CMD_DEC, {ALT5, ALTA});
    block_send(CMD_ENC, '0);
    block_send(CMD_ENC, '1);

    for (int ph = 0; ph < 10; ph++) begin
      rekey(ph);
      random_blocks(60, 1'b1);
    end

    drain();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && blocks_owed == 0) begin
      $display("lucifer_block_cipher_core_test: clean");
    end else begin
      $display("lucifer_block_cipher_core_test: errors");
    end
    $finish;
  end

endmodule
